>>> hw/rtl/npc_pkg.sv
// Shared types and constants of the nearest prototype classifier.
// Request and result structs, request codes, register indexes, widths.
// No dependencies.
`default_nettype none

package npc_pkg;

    // Sizes fixed by the field definitions
    localparam int NPC_MAX_PROTOTYPES = 16;
    localparam int FEATURE_COUNT      = 4;
    localparam int FEAT_W             = 12;
    localparam int PROTO_W            = 16;
    localparam int SUM_W              = 28;
    localparam int CNT_W              = 16;
    localparam int CFG_W              = 5;
    localparam int CFG_IDX_W          = 1;
    localparam int IDX_OUT_W          = 4;
    localparam int SLOT_W             = 4;
    localparam int QUO_W              = 12;
    // (feature - bias) * 16 - proto fits in 18 signed bits
    localparam int DIFF_W             = 18;
    localparam int SQ_W               = 2 * DIFF_W;
    localparam int DIST_W             = SQ_W + 1;

    localparam logic [CNT_W-1:0] SAMPLE_CAP = 16'd65535;

    // Request codes
    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_TRAIN   = 2'd1;
    localparam logic [1:0] REQ_PREDICT = 2'd2;

    // Axis codes
    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_Y = 1'b1;

    // Status codes
    localparam logic ST_OK     = 1'b0;
    localparam logic ST_REJECT = 1'b1;

    typedef struct packed {
        logic [1:0]               req_type;
        logic                     axis;
        logic [SLOT_W-1:0]        entry_index;
        logic signed [PROTO_W-1:0] proto_a;
        logic signed [PROTO_W-1:0] proto_b;
        logic [FEAT_W-1:0]        feature_0;
        logic [FEAT_W-1:0]        feature_1;
        logic [FEAT_W-1:0]        feature_2;
        logic [FEAT_W-1:0]        feature_3;
    } t_req;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] index_x;
        logic [IDX_OUT_W-1:0] index_y;
        logic                 trained;
        logic                 status;
    } t_rsp;

endpackage

`default_nettype wire

>>> hw/rtl/npc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds one prototype table of the classifier. No dependencies.
`default_nettype none

module npc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/nearest_prototype_classifier_core.sv
// Nearest prototype classifier core: prototype tables, training sums, bias divider, search.
// Depends on npc_pkg and npc_ram.
`default_nettype none

// Usage
//   Request channel: an item is taken at a clock edge with start high and busy low.
//   req_type selects load (write one prototype of the chosen axis), train (add a
//   sample to the running sums) or predict (nearest prototype per axis).
//   Result channel: o_done is high for exactly one cycle with o_rsp; it cannot be
//   held off, so the block never stalls on the output side.
//   Configuration: i_cfg_we writes count_x (index 0) or count_y (index 1); write
//   only while busy is low and no result is pending.
// Sequence (busy high from the start edge until the o_done cycle)
//   load, reject, unknown request: the execute step only.
//   train: execute, then the trained check; with a bias update, the 12-step
//   restoring divider follows (one quotient bit per cycle, four lanes in parallel).
//   predict: the walk over N = max(count_x, count_y) entries after clamping, then the
//   search pipeline drains; the walk reads one entry of each table RAM per cycle.
//   The next request may be started in the cycle that o_done is high.
// Reset: synchronous, clears sums, sample count, biases and counts to 1.
//   Prototype tables are not cleared; an entry must be loaded before use.
module nearest_prototype_classifier_core
    import npc_pkg::*;
#(
    parameter int MAX_PROTOTYPES = NPC_MAX_PROTOTYPES
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    input  wire t_req                 i_req,
    output logic                      busy,
    output logic                      o_done,
    output t_rsp                      o_rsp,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(MAX_PROTOTYPES);
    localparam int CW = $clog2(MAX_PROTOTYPES + 1);
    localparam int PW = 2 * CW;
    localparam int BIT_W = $clog2(QUO_W);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_PREDIV = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_WALK   = 3'd4;

    // Count of 0 acts as 1, above the table depth as the depth
    function automatic logic [CW-1:0] eff_count(input logic [CFG_W-1:0] c);
        logic [CW-1:0] res;
        if (c == '0) begin
            res = CW'(1);
        end else if (32'(c) > MAX_PROTOTYPES) begin
            res = CW'(MAX_PROTOTYPES);
        end else begin
            res = CW'(c);
        end
        return res;
    endfunction

    // (feature - bias) scaled to Q.4
    function automatic logic signed [DIFF_W-1:0] scale_feat(
        input logic [FEAT_W-1:0] f,
        input logic [FEAT_W-1:0] b
    );
        logic signed [FEAT_W:0] h;
        h = $signed({1'b0, f}) - $signed({1'b0, b});
        return {h[FEAT_W], h, 4'b0000};
    endfunction

    // Control and state registers
    logic [2:0]             r_state, n_state;
    t_req                   r_req, n_req;
    logic                   r_done, n_done;
    t_rsp                   r_rsp, n_rsp;
    logic [CFG_W-1:0]       r_cnt_x, n_cnt_x;
    logic [CFG_W-1:0]       r_cnt_y, n_cnt_y;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [SUM_W-1:0]       r_sum [FEATURE_COUNT];
    logic [SUM_W-1:0]       n_sum [FEATURE_COUNT];
    logic [FEAT_W-1:0]      r_bias [FEATURE_COUNT];
    logic [FEAT_W-1:0]      n_bias [FEATURE_COUNT];
    // Divider lanes
    logic [SUM_W-1:0]       r_rem [FEATURE_COUNT];
    logic [SUM_W-1:0]       n_rem [FEATURE_COUNT];
    logic [QUO_W-1:0]       r_quo [FEATURE_COUNT];
    logic [QUO_W-1:0]       n_quo [FEATURE_COUNT];
    logic [SUM_W-1:0]       r_dsh, n_dsh;
    logic [BIT_W-1:0]       r_bit, n_bit;
    // Search
    logic [CW-1:0]          r_walk, n_walk;
    logic signed [DIFF_W-1:0] r_px_a, n_px_a, r_px_b, n_px_b;
    logic signed [DIFF_W-1:0] r_py_a, n_py_a, r_py_b, n_py_b;
    logic                   r_first_x, n_first_x, r_first_y, n_first_y;
    logic [DIST_W-1:0]      r_best_dx, n_best_dx, r_best_dy, n_best_dy;
    logic [AW-1:0]          r_best_ix, n_best_ix, r_best_iy, n_best_iy;
    // Search pipeline
    logic                   r_s1_v, r_s2_v, r_s2_vx, r_s2_vy;
    logic [AW-1:0]          r_s1_idx, r_s2_idx;
    logic signed [SQ_W-1:0] r_sq_xa, r_sq_xb, r_sq_ya, r_sq_yb;

    // Combinational helpers
    logic [CW-1:0]          w_nx, w_ny, w_n_max, w_n_load;
    logic [PW-1:0]          w_prod;
    logic                   w_trained;
    logic                   w_load_ok;
    logic                   w_we_x, w_we_y;
    logic                   w_issue;
    logic [AW-1:0]          w_raddr, w_waddr;
    logic [2*PROTO_W-1:0]   w_wdata, w_rdata_x, w_rdata_y;
    logic signed [DIFF_W-1:0] w_dxa, w_dxb, w_dya, w_dyb;
    logic signed [SQ_W-1:0] w_sq_xa, w_sq_xb, w_sq_ya, w_sq_yb;
    logic [DIST_W-1:0]      w_dist_x, w_dist_y;
    logic [FEAT_W-1:0]      w_feat [FEATURE_COUNT];
    logic                   w_ge [FEATURE_COUNT];

    assign w_feat[0] = r_req.feature_0;
    assign w_feat[1] = r_req.feature_1;
    assign w_feat[2] = r_req.feature_2;
    assign w_feat[3] = r_req.feature_3;

    // Effective counts and the trained flag
    assign w_nx      = eff_count(r_cnt_x);
    assign w_ny      = eff_count(r_cnt_y);
    assign w_n_max   = (w_nx > w_ny) ? w_nx : w_ny;
    assign w_prod    = PW'(w_nx) * PW'(w_ny);
    assign w_trained = 32'(r_count) >= 32'(w_prod);

    // Prototype load check and table writes
    assign w_n_load  = (r_req.axis == AXIS_Y) ? w_ny : w_nx;
    assign w_load_ok = 32'(r_req.entry_index) < 32'(w_n_load);
    assign w_we_x    = (r_state == S_EXEC) && (r_req.req_type == REQ_LOAD) && w_load_ok
                       && (r_req.axis == AXIS_X);
    assign w_we_y    = (r_state == S_EXEC) && (r_req.req_type == REQ_LOAD) && w_load_ok
                       && (r_req.axis == AXIS_Y);
    assign w_waddr   = AW'(r_req.entry_index);
    assign w_wdata   = {r_req.proto_a, r_req.proto_b};

    // Search address issue
    assign w_issue   = (r_state == S_WALK) && (r_walk < w_n_max);
    assign w_raddr   = r_walk[AW-1:0];

    npc_ram #(
        .WIDTH (2 * PROTO_W),
        .DEPTH (MAX_PROTOTYPES)
    ) u_ram_x (
        .i_clk   (i_clk),
        .i_we    (w_we_x),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_x)
    );

    npc_ram #(
        .WIDTH (2 * PROTO_W),
        .DEPTH (MAX_PROTOTYPES)
    ) u_ram_y (
        .i_clk   (i_clk),
        .i_we    (w_we_y),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_y)
    );

    // Stage 1: differences and squares of the entry read last cycle
    assign w_dxa = r_px_a - {{2{w_rdata_x[2*PROTO_W-1]}}, w_rdata_x[2*PROTO_W-1:PROTO_W]};
    assign w_dxb = r_px_b - {{2{w_rdata_x[PROTO_W-1]}}, w_rdata_x[PROTO_W-1:0]};
    assign w_dya = r_py_a - {{2{w_rdata_y[2*PROTO_W-1]}}, w_rdata_y[2*PROTO_W-1:PROTO_W]};
    assign w_dyb = r_py_b - {{2{w_rdata_y[PROTO_W-1]}}, w_rdata_y[PROTO_W-1:0]};
    assign w_sq_xa = w_dxa * w_dxa;
    assign w_sq_xb = w_dxb * w_dxb;
    assign w_sq_ya = w_dya * w_dya;
    assign w_sq_yb = w_dyb * w_dyb;

    // Stage 2: distances (squares are never negative)
    assign w_dist_x = {1'b0, r_sq_xa} + {1'b0, r_sq_xb};
    assign w_dist_y = {1'b0, r_sq_ya} + {1'b0, r_sq_yb};

    // Divider lane compare
    always_comb begin
        for (int k = 0; k < FEATURE_COUNT; k++) begin
            w_ge[k] = r_rem[k] >= r_dsh;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_done    = 1'b0;
        n_rsp     = r_rsp;
        n_cnt_x   = r_cnt_x;
        n_cnt_y   = r_cnt_y;
        n_count   = r_count;
        n_sum     = r_sum;
        n_bias    = r_bias;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_dsh     = r_dsh;
        n_bit     = r_bit;
        n_walk    = r_walk;
        n_px_a    = r_px_a;
        n_px_b    = r_px_b;
        n_py_a    = r_py_a;
        n_py_b    = r_py_b;
        n_first_x = r_first_x;
        n_first_y = r_first_y;
        n_best_dx = r_best_dx;
        n_best_dy = r_best_dy;
        n_best_ix = r_best_ix;
        n_best_iy = r_best_iy;

        // Register writes
        if (i_cfg_we && (i_cfg_idx == CFG_COUNT_X)) begin
            n_cnt_x = i_cfg_data;
        end
        if (i_cfg_we && (i_cfg_idx == CFG_COUNT_Y)) begin
            n_cnt_y = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req   = i_req;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_rsp.index_x = '0;
                n_rsp.index_y = '0;
                n_rsp.trained = w_trained;
                n_rsp.status  = ST_REJECT;
                unique case (r_req.req_type)
                    REQ_LOAD: begin
                        n_rsp.status = w_load_ok ? ST_OK : ST_REJECT;
                        n_done       = 1'b1;
                        n_state      = S_IDLE;
                    end
                    REQ_TRAIN: begin
                        if (r_count < SAMPLE_CAP) begin
                            n_count = CNT_W'(r_count + CNT_W'(1));
                            for (int k = 0; k < FEATURE_COUNT; k++) begin
                                n_sum[k] = SUM_W'(r_sum[k] + SUM_W'(w_feat[k]));
                            end
                            n_state = S_PREDIV;
                        end else begin
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    REQ_PREDICT: begin
                        n_px_a    = scale_feat(r_req.feature_0, r_bias[0]);
                        n_px_b    = scale_feat(r_req.feature_2, r_bias[2]);
                        n_py_a    = scale_feat(r_req.feature_1, r_bias[1]);
                        n_py_b    = scale_feat(r_req.feature_3, r_bias[3]);
                        n_walk    = '0;
                        n_first_x = 1'b1;
                        n_first_y = 1'b1;
                        n_best_ix = '0;
                        n_best_iy = '0;
                        n_state   = S_WALK;
                    end
                    default: begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end

            // Count already advanced; start the mean division if trained
            S_PREDIV: begin
                if (w_trained) begin
                    n_rem   = r_sum;
                    n_dsh   = SUM_W'({r_count, (QUO_W - 1)'(0)});
                    n_bit   = BIT_W'(QUO_W - 1);
                    n_state = S_DIV;
                end else begin
                    n_rsp.index_x = '0;
                    n_rsp.index_y = '0;
                    n_rsp.trained = w_trained;
                    n_rsp.status  = ST_OK;
                    n_done        = 1'b1;
                    n_state       = S_IDLE;
                end
            end

            // Restoring division, one quotient bit per cycle; sums never exceed
            // count * 4095, so 12 quotient bits hold the mean
            S_DIV: begin
                for (int k = 0; k < FEATURE_COUNT; k++) begin
                    n_rem[k] = w_ge[k] ? SUM_W'(r_rem[k] - r_dsh) : r_rem[k];
                    n_quo[k] = {r_quo[k][QUO_W-2:0], w_ge[k]};
                end
                n_dsh = r_dsh >> 1;
                n_bit = BIT_W'(r_bit - BIT_W'(1));
                if (r_bit == '0) begin
                    for (int k = 0; k < FEATURE_COUNT; k++) begin
                        n_bias[k] = {r_quo[k][QUO_W-2:0], w_ge[k]};
                    end
                    n_rsp.index_x = '0;
                    n_rsp.index_y = '0;
                    n_rsp.trained = w_trained;
                    n_rsp.status  = ST_OK;
                    n_done        = 1'b1;
                    n_state       = S_IDLE;
                end
            end

            // Walk both tables; keep the first least distance
            S_WALK: begin
                if (w_issue) begin
                    n_walk = CW'(r_walk + CW'(1));
                end
                if (r_s2_vx && (r_first_x || (w_dist_x < r_best_dx))) begin
                    n_best_dx = w_dist_x;
                    n_best_ix = r_s2_idx;
                    n_first_x = 1'b0;
                end
                if (r_s2_vy && (r_first_y || (w_dist_y < r_best_dy))) begin
                    n_best_dy = w_dist_y;
                    n_best_iy = r_s2_idx;
                    n_first_y = 1'b0;
                end
                if (!w_issue && !r_s1_v && !r_s2_v) begin
                    n_rsp.index_x = IDX_OUT_W'(r_best_ix);
                    n_rsp.index_y = IDX_OUT_W'(r_best_iy);
                    n_rsp.trained = w_trained;
                    n_rsp.status  = ST_OK;
                    n_done        = 1'b1;
                    n_state       = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cnt_x <= CFG_W'(1);
            r_cnt_y <= CFG_W'(1);
            r_count <= '0;
            for (int k = 0; k < FEATURE_COUNT; k++) begin
                r_sum[k]  <= '0;
                r_bias[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt_x <= n_cnt_x;
            r_cnt_y <= n_cnt_y;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_bias  <= n_bias;
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_rsp     <= n_rsp;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_dsh     <= n_dsh;
        r_bit     <= n_bit;
        r_walk    <= n_walk;
        r_px_a    <= n_px_a;
        r_px_b    <= n_px_b;
        r_py_a    <= n_py_a;
        r_py_b    <= n_py_b;
        r_first_x <= n_first_x;
        r_first_y <= n_first_y;
        r_best_dx <= n_best_dx;
        r_best_dy <= n_best_dy;
        r_best_ix <= n_best_ix;
        r_best_iy <= n_best_iy;
    end

    // Search pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s2_vx <= 1'b0;
            r_s2_vy <= 1'b0;
        end else begin
            r_s1_v  <= w_issue;
            r_s2_v  <= r_s1_v;
            r_s2_vx <= r_s1_v && (32'(r_s1_idx) < 32'(w_nx));
            r_s2_vy <= r_s1_v && (32'(r_s1_idx) < 32'(w_ny));
        end
    end

    // Search pipeline payload
    always_ff @(posedge i_clk) begin
        r_s1_idx <= w_raddr;
        r_s2_idx <= r_s1_idx;
        r_sq_xa  <= w_sq_xa;
        r_sq_xb  <= w_sq_xb;
        r_sq_ya  <= w_sq_ya;
        r_sq_yb  <= w_sq_yb;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // An accepted request always makes the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // A result only follows work in progress
    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) != S_IDLE))
        else $error("result strobe without a request in progress");

    // Tables are written only by a load in the execute step
    a_table_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we_x || w_we_y) |-> ((r_state == S_EXEC) && (r_req.req_type == REQ_LOAD)
                                 && !(w_we_x && w_we_y)))
        else $error("prototype table written outside a load");

    // Sample count only ever steps up by one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count)))
            |-> (r_count == CNT_W'($past(r_count) + CNT_W'(1))))
        else $error("sample count changed by other than one");

    // Search pipeline runs only during a predict walk
    a_pipe_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v || r_s2_v) |-> (r_state == S_WALK))
        else $error("search pipeline active outside the walk");

endmodule

`default_nettype wire

>>> tb/classifier_scoreboard_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the nearest prototype classifier testbench: a bit-true
// prediction of the core's responses and the queue of responses still owed.
// Depends on npc_pkg.

package classifier_scoreboard_pkg;
    import npc_pkg::*;

    // Request code with no meaning to the core
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    class classifier_scoreboard;
        logic [CFG_W-1:0]  count_x;
        logic [CFG_W-1:0]  count_y;
        int                proto_a [2][NPC_MAX_PROTOTYPES];
        int                proto_b [2][NPC_MAX_PROTOTYPES];
        logic [SUM_W-1:0]  feat_sum [FEATURE_COUNT];
        logic [CNT_W-1:0]  n_samples;
        logic [FEAT_W-1:0] bias [FEATURE_COUNT];
        t_rsp              expected_rsp_q [$];
        int                errors;

        function new();
            count_x   = 1;
            count_y   = 1;
            n_samples = '0;
            errors    = 0;
            foreach (feat_sum[i]) feat_sum[i] = '0;
            foreach (bias[i]) bias[i] = '0;
            foreach (proto_a[a, s]) begin
                proto_a[a][s] = 0;
                proto_b[a][s] = 0;
            end
        endfunction

        // Counts below 1 act as 1, above the table size as the table size
        function int unsigned clamp_count(logic [CFG_W-1:0] c);
            if (c == 0) return 1;
            if (c > NPC_MAX_PROTOTYPES) return NPC_MAX_PROTOTYPES;
            return c;
        endfunction

        function bit is_trained();
            return 32'(n_samples) >= clamp_count(count_x) * clamp_count(count_y);
        endfunction

        function void set_count(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            if (idx == CFG_COUNT_X) count_x = value;
            else count_y = value;
        endfunction

        // Least squared distance over the live slots; ties keep the lower slot
        function logic [IDX_OUT_W-1:0] nearest_slot(logic ax, int f_a, int f_b);
            int unsigned          n;
            longint               da;
            longint               db;
            longint               d;
            longint               best_d;
            logic [IDX_OUT_W-1:0] best;
            n      = clamp_count(ax == AXIS_Y ? count_y : count_x);
            best   = '0;
            best_d = 0;
            for (int i = 0; i < n; i++) begin
                da = longint'(f_a) * 16 - longint'(proto_a[ax][i]);
                db = longint'(f_b) * 16 - longint'(proto_b[ax][i]);
                d  = da * da + db * db;
                if (i == 0 || d < best_d) begin
                    best   = IDX_OUT_W'(i);
                    best_d = d;
                end
            end
            return best;
        endfunction

        // Apply one accepted request and queue the response it must produce
        function void note_request(t_req r);
            t_rsp              rsp;
            logic [FEAT_W-1:0] f [FEATURE_COUNT];
            int unsigned       n;
            f          = '{r.feature_0, r.feature_1, r.feature_2, r.feature_3};
            rsp        = '0;
            rsp.status = ST_REJECT;
            case (r.req_type)
                REQ_LOAD: begin
                    n = clamp_count(r.axis == AXIS_Y ? count_y : count_x);
                    if (r.entry_index < n) begin
                        proto_a[r.axis][r.entry_index] = int'($signed(r.proto_a));
                        proto_b[r.axis][r.entry_index] = int'($signed(r.proto_b));
                        rsp.status = ST_OK;
                    end
                end
                REQ_TRAIN: begin
                    // at the cap the sample is turned away untouched
                    if (n_samples < SAMPLE_CAP) begin
                        n_samples++;
                        foreach (feat_sum[i]) feat_sum[i] += SUM_W'(f[i]);
                        if (is_trained()) begin
                            foreach (bias[i])
                                bias[i] = FEAT_W'(feat_sum[i] / SUM_W'(n_samples));
                        end
                        rsp.status = ST_OK;
                    end
                end
                REQ_PREDICT: begin
                    rsp.index_x = nearest_slot(AXIS_X, int'(f[0]) - int'(bias[0]),
                                               int'(f[2]) - int'(bias[2]));
                    rsp.index_y = nearest_slot(AXIS_Y, int'(f[1]) - int'(bias[1]),
                                               int'(f[3]) - int'(bias[3]));
                    rsp.status  = ST_OK;
                end
                default: ;
            endcase
            rsp.trained = is_trained();
            expected_rsp_q = {expected_rsp_q, rsp};
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
            end
        endfunction

        // Match a response against the oldest outstanding request
        function void check_response(t_rsp got);
            t_rsp want;
            if (expected_rsp_q.size() == 0) begin
                errors++;
                $display("%0t: response with none expected, expected none, actual %p",
                         $time, got);
                return;
            end
            want = expected_rsp_q.pop_front();
            compare_field("index_x", want.index_x, got.index_x);
            compare_field("index_y", want.index_y, got.index_y);
            compare_field("trained", want.trained, got.trained);
            compare_field("status", want.status, got.status);
        endfunction
    endclass

endpackage

>>> tb/nearest_prototype_classifier_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for nearest_prototype_classifier_core: directed and random
// requests with random idle gaps, responses checked by the scoreboard class.
// Depends on npc_pkg, classifier_scoreboard_pkg and the core RTL.

module nearest_prototype_classifier_core_tb;
    import npc_pkg::*;
    import classifier_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT   = 5_000_000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 240;
    localparam int DRAIN_CYCLES  = 30;

    logic                 i_clk;
    logic                 i_rst_n    = 1'b0;
    logic                 start      = 1'b0;
    t_req                 i_req      = '0;
    logic                 busy;
    logic                 o_done;
    t_rsp                 o_rsp;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = CFG_COUNT_X;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    bit                   gaps_on    = 1'b1;

    classifier_scoreboard sb = new();

    nearest_prototype_classifier_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req      (i_req),
        .busy       (busy),
        .o_done     (o_done),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Responses last one cycle and cannot be held off
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_response(o_rsp);
    end

    // Present one request and hold it until the core takes it
    task automatic send_req(t_req r);
        i_req <= r;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_request(r);
    endtask

    // Mostly short gaps, now and then a long one
    task automatic idle_gap();
        int n;
        int pick;
        n = 0;
        if (gaps_on) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) n = 0;
            else if (pick < 85) n = $urandom_range(1, 3);
            else if (pick < 97) n = $urandom_range(4, 12);
            else n = $urandom_range(20, 60);
        end
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Stop sending until every outstanding request is answered
    task automatic drain();
        start <= 1'b0;
        while (sb.expected_rsp_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Both count registers, one per cycle; core must be idle
    task automatic set_counts(logic [CFG_W-1:0] cx, logic [CFG_W-1:0] cy);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_COUNT_X;
        i_cfg_data <= cx;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_COUNT_Y;
        i_cfg_data <= cy;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_count(CFG_COUNT_X, cx);
        sb.set_count(CFG_COUNT_Y, cy);
    endtask

    function automatic logic [FEAT_W-1:0] rand_feature();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return FEAT_W'($urandom);
        endcase
    endfunction

    // Half the coordinates sit on a coarse grid so equal distances occur
    function automatic logic [PROTO_W-1:0] rand_coord();
        int k;
        k = int'($urandom_range(0, 7)) - 4;
        if ($urandom_range(0, 1) == 0) return PROTO_W'(k * 4096);
        return PROTO_W'($urandom);
    endfunction

    function automatic t_req make_req(logic [1:0] kind);
        t_req r;
        r.req_type    = kind;
        r.axis        = 1'($urandom);
        r.entry_index = SLOT_W'($urandom);
        r.proto_a     = rand_coord();
        r.proto_b     = rand_coord();
        r.feature_0   = rand_feature();
        r.feature_1   = rand_feature();
        r.feature_2   = rand_feature();
        r.feature_3   = rand_feature();
        return r;
    endfunction

    function automatic t_req load_req(logic ax, int slot, int a, int b);
        t_req r;
        r             = make_req(REQ_LOAD);
        r.axis        = ax;
        r.entry_index = SLOT_W'(slot);
        r.proto_a     = PROTO_W'(a);
        r.proto_b     = PROTO_W'(b);
        return r;
    endfunction

    // All four features set to one value
    function automatic t_req feat_req(logic [1:0] kind, logic [FEAT_W-1:0] f);
        t_req r;
        r           = make_req(kind);
        r.feature_0 = f;
        r.feature_1 = f;
        r.feature_2 = f;
        r.feature_3 = f;
        return r;
    endfunction

    initial begin
        t_req r;
        int   pick;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset counts 1 x 1: one live slot per table, untrained
        send_req(load_req(AXIS_X, 0, 32767, -32768));
        send_req(load_req(AXIS_Y, 0, -32768, 32767));
        // slots past the live count are rejected
        send_req(load_req(AXIS_X, 1, 16, 16));
        send_req(load_req(AXIS_Y, 15, 16, 16));
        r          = '1;
        r.req_type = REQ_UNKNOWN;
        send_req(r);
        send_req(feat_req(REQ_PREDICT, '0));
        // a single sample trains a 1 x 1 grid; bias becomes that sample
        send_req(feat_req(REQ_TRAIN, '1));
        send_req(feat_req(REQ_PREDICT, '0));
        send_req(feat_req(REQ_PREDICT, '1));
        drain();

        // Out-of-range counts: 31 acts as 16, 0 acts as 1
        set_counts(5'd31, 5'd0);
        send_req(load_req(AXIS_Y, 1, 0, 0));
        send_req(load_req(AXIS_X, 15, -32768, 32767));
        drain();
        set_counts(5'd31, 5'd17);

        // Load every slot of both tables before any wide search
        for (int ax = 0; ax < 2; ax++) begin
            for (int s = 0; s < NPC_MAX_PROTOTYPES; s++)
                send_req(load_req(1'(ax), s, rand_coord(), rand_coord()));
        end
        send_req(feat_req(REQ_PREDICT, 12'd2048));
        send_req(feat_req(REQ_TRAIN, '0));
        drain();

        // Ties: equidistant prototypes, the lower slot wins
        set_counts(5'd2, 5'd2);
        send_req(load_req(AXIS_X, 0, 160, -160));
        send_req(load_req(AXIS_X, 1, -160, 160));
        send_req(load_req(AXIS_Y, 0, 48, 48));
        send_req(load_req(AXIS_Y, 1, 48, 48));
        send_req(feat_req(REQ_PREDICT, '1));
        send_req(load_req(AXIS_X, 0, 320, 320));
        send_req(load_req(AXIS_Y, 0, 480, 0));
        send_req(feat_req(REQ_PREDICT, '1));
        // reaching count_x * count_y samples switches the bias on
        send_req(feat_req(REQ_TRAIN, '0));
        send_req(feat_req(REQ_TRAIN, '0));
        send_req(feat_req(REQ_PREDICT, 12'd1023));
        drain();

        // Random phases, each under its own count setting
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: set_counts(5'd16, 5'd16);
                1: set_counts(5'd1, 5'd1);
                2: set_counts(5'd0, 5'd31);
                3: set_counts(5'd16, 5'd1);
                default: set_counts(5'($urandom), 5'($urandom));
            endcase
            gaps_on = (p % 3 != 1);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 25) r = make_req(REQ_LOAD);
                else if (pick < 55) r = make_req(REQ_TRAIN);
                else if (pick < 96) r = make_req(REQ_PREDICT);
                else r = make_req(REQ_UNKNOWN);
                send_req(r);
                idle_gap();
                // hold off mid-phase until every response is back
                if (k == PHASE_ITEMS / 2) drain();
            end
            drain();
        end

        // Full grid, then a short mixed tail back to back
        set_counts(5'd16, 5'd16);
        send_req(feat_req(REQ_TRAIN, '1));
        send_req(feat_req(REQ_TRAIN, '0));
        send_req(make_req(REQ_PREDICT));
        send_req(make_req(REQ_PREDICT));
        send_req(load_req(AXIS_Y, 15, 0, 0));
        drain();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_rsp_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/npc_pkg.sv
hw/rtl/npc_ram.sv
hw/rtl/nearest_prototype_classifier_core.sv
tb/classifier_scoreboard_pkg.sv
tb/nearest_prototype_classifier_core_tb.sv
